@@ sv/hfne_pkg.sv @@
package hfne_pkg;

   // command codes of an input word
   localparam logic [1:0] CMD_FLAG  = 2'd0;
   localparam logic [1:0] CMD_FRAME = 2'd1;
   localparam logic [1:0] CMD_FCS   = 2'd2;
   localparam logic [1:0] CMD_IDLE  = 2'd3;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [2:0] RUN_LIMIT    = 3'd5;
   localparam logic [4:0] PERIOD_LIMIT = 5'd19;
   localparam logic [4:0] BYTE_BITS    = 5'd8;
   localparam logic [4:0] FCS_BITS     = 5'd16;

   localparam int QUEUE_DEPTH = 2;

   // one queued command, the word is the byte or the complemented fcs
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] bits;
   } entry_type;

   // reflected crc-16, one byte folded in lsb first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ sv/hfne_if.sv @@
interface hfne_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface hfne_rsp_if;
   logic valid;
   logic ready;
   logic tone_high;
   logic stuffed_bit;
   logic last;

   modport source (output valid, output tone_high, output stuffed_bit, output last,
                   input ready);
   modport sink (input valid, input tone_high, input stuffed_bit, input last,
                 output ready);
endinterface

@@ sv/hfne_front.sv @@
module hfne_front (
   input  logic                 clock,
   input  logic                 reset,
   hfne_req_if.sink             req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output hfne_pkg::entry_type  push_entry
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        accept;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   always_comb begin
      push_entry.cmd  = req_chan.command;
      push_entry.bits = 16'h0000;
      crc_in          = crc_ff;
      case (req_chan.command)
         hfne_pkg::CMD_FLAG: begin
            push_entry.bits = {8'h00, req_chan.data_byte};
            crc_in          = hfne_pkg::CRC_INIT;
         end
         hfne_pkg::CMD_FRAME: begin
            push_entry.bits = {8'h00, req_chan.data_byte};
            crc_in          = hfne_pkg::crc_fold(crc_ff, req_chan.data_byte);
         end
         hfne_pkg::CMD_FCS: begin
            push_entry.bits = ~crc_ff;
         end
         default: begin
            push_entry.bits = 16'h0000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= hfne_pkg::CRC_INIT;
      end else if (accept) begin
         crc_ff <= crc_in;
      end
   end

endmodule

@@ sv/hfne_queue.sv @@
module hfne_queue #(
   parameter int DEPTH = hfne_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  hfne_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output hfne_pkg::entry_type  pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hfne_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          push;
   logic          pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ sv/hfne_back.sv @@
module hfne_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  hfne_pkg::entry_type  pop_entry,
   hfne_rsp_if.source           rsp_chan
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_OWED  = 2'd1;
   localparam logic [1:0] PH_BITS  = 2'd2;
   localparam logic [1:0] PH_STUFF = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] word_ff, word_in;
   logic [4:0]  left_ff, left_in;
   logic [4:0]  count_ff, count_in;
   logic        tone_ff, tone_in;
   logic [2:0]  run_ff, run_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_tone_ff, out_stuff_ff, out_last_ff;

   logic        can_emit;
   logic        emit;
   logic        e_tone;
   logic        e_stuff;
   logic        e_last;
   logic        bit_now;
   logic [2:0]  run_bit;
   logic        need_stuff;
   logic        room;
   logic        load;

   assign can_emit = !out_valid_ff || rsp_chan.ready;
   assign bit_now  = word_ff[0];
   assign run_bit  = bit_now ? run_ff + 3'd1 : 3'd0;
   assign need_stuff = (run_bit >= hfne_pkg::RUN_LIMIT);
   // stuff only if the zero and all later data bits still fit
   assign room = ({1'b0, count_ff} + {1'b0, left_ff}) <=
                 ({1'b0, hfne_pkg::PERIOD_LIMIT} - 6'd1);

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      word_in  = word_ff;
      left_in  = left_ff;
      count_in = count_ff;
      tone_in  = tone_ff;
      run_in   = run_ff;
      emit     = 1'b0;
      e_tone   = tone_ff;
      e_stuff  = 1'b0;
      e_last   = 1'b0;

      if (can_emit) begin
         case (phase_ff)
            PH_OWED: begin
               emit     = 1'b1;
               tone_in  = ~tone_ff;
               e_tone   = ~tone_ff;
               e_stuff  = 1'b1;
               run_in   = 3'd0;
               count_in = count_ff + 5'd1;
               phase_in = PH_BITS;
            end
            PH_BITS: begin
               emit = 1'b1;
               case (cmd_ff)
                  hfne_pkg::CMD_IDLE: begin
                     e_tone   = 1'b0;
                     e_last   = 1'b1;
                     phase_in = PH_IDLE;
                  end
                  hfne_pkg::CMD_FLAG: begin
                     tone_in  = tone_ff ^ ~bit_now;
                     e_tone   = tone_ff ^ ~bit_now;
                     word_in  = word_ff >> 1;
                     left_in  = left_ff - 5'd1;
                     count_in = count_ff + 5'd1;
                     run_in   = 3'd0;
                     e_last   = (left_ff == 5'd1);
                     if (e_last) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     tone_in  = tone_ff ^ ~bit_now;
                     e_tone   = tone_ff ^ ~bit_now;
                     word_in  = word_ff >> 1;
                     left_in  = left_ff - 5'd1;
                     count_in = count_ff + 5'd1;
                     run_in   = run_bit;
                     if (need_stuff && room) begin
                        run_in   = 3'd0;
                        phase_in = PH_STUFF;
                     end else if (need_stuff && left_ff == 5'd1) begin
                        // zero is owed to the next word
                        run_in   = hfne_pkg::RUN_LIMIT;
                     end else if (need_stuff) begin
                        run_in   = 3'd0;
                     end
                     e_last = (left_ff == 5'd1) && !(need_stuff && room);
                     if (e_last) begin
                        phase_in = PH_IDLE;
                     end
                  end
               endcase
            end
            PH_STUFF: begin
               emit     = 1'b1;
               tone_in  = ~tone_ff;
               e_tone   = ~tone_ff;
               e_stuff  = 1'b1;
               run_in   = 3'd0;
               count_in = count_ff + 5'd1;
               e_last   = (left_ff == 5'd0);
               phase_in = e_last ? PH_IDLE : PH_BITS;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      // next word enters as the current one finishes, no gap
      load = pop_valid && ((phase_ff == PH_IDLE) || (emit && e_last));
      if (load) begin
         cmd_in   = pop_entry.cmd;
         word_in  = pop_entry.bits;
         left_in  = (pop_entry.cmd == hfne_pkg::CMD_FCS) ? hfne_pkg::FCS_BITS
                                                          : hfne_pkg::BYTE_BITS;
         count_in = 5'd0;
         phase_in = (run_in == hfne_pkg::RUN_LIMIT) ? PH_OWED : PH_BITS;
      end

      out_valid_in = emit || (out_valid_ff && !rsp_chan.ready);
   end

   assign pop_ready = pop_valid && load;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tone_ff      <= 1'b0;
         run_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tone_ff      <= tone_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      word_ff  <= word_in;
      left_ff  <= left_in;
      count_ff <= count_in;
      if (emit) begin
         out_tone_ff  <= e_tone;
         out_stuff_ff <= e_stuff;
         out_last_ff  <= e_last;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.tone_high   = out_tone_ff;
   assign rsp_chan.stuffed_bit = out_stuff_ff;
   assign rsp_chan.last        = out_last_ff;

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= hfne_pkg::RUN_LIMIT)
      else $error("ones run beyond limit");

   a_stuff_toggles: assert property (@(posedge clock) disable iff (reset)
      (emit && e_stuff) |=> (tone_ff != $past(tone_ff)))
      else $error("stuffed zero did not toggle the tone");

   a_period_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (count_ff < hfne_pkg::PERIOD_LIMIT))
      else $error("word ran past its period limit");

   a_owed_only_when_due: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OWED) |-> (run_ff == hfne_pkg::RUN_LIMIT))
      else $error("owed zero without a full run");

endmodule

@@ sv/hdlc_fcs_nrzi_bit_encoder.sv @@
// hdlc transmit line encoder, nrzi coded, for an afsk tone modulator
//
// req_chan takes one command word per handshake: a flag byte (sent lsb first,
// unstuffed, restarts the crc), a frame byte (sent lsb first with bit stuffing,
// folded into the crc-16), an fcs command (complemented crc, low byte first,
// stuffed) or an idle command (one low-tone period).
// rsp_chan gives one word per bit period: tone_high, stuffed_bit, and last on
// the final period of a command. a command gives 1 to 19 periods.
// throughput: one period per cycle while rsp_chan is not stalled; the next
// command is loaded as the last period of the previous one is emitted, so
// commands follow each other with no gap.
// the first period of a command passes the queue, the serializer registers
// and the output register before it shows on rsp_chan.
// a small command queue sits between the crc front and the serializer, so
// req_chan keeps accepting while rsp_chan is stalled until the queue is full;
// a stalled output word holds in the output register.
// reset clears the line tone to low, the ones run to zero, the crc to all
// ones, and empties the queue and the output register.
module hdlc_fcs_nrzi_bit_encoder #(
   parameter int QUEUE_DEPTH = hfne_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   hfne_req_if.sink    req_chan,
   hfne_rsp_if.source  rsp_chan
);

   logic                push_valid;
   logic                push_ready;
   hfne_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop_ready;
   hfne_pkg::entry_type pop_entry;

   hfne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   hfne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   hfne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule
